/* src/rvx_pkg.sv */
`default_nettype none
package rvx_pkg;

  localparam int unsigned MEM_BYTES_DEF = 16384;

  // item kinds
  localparam logic [1:0] FUNC_EXEC   = 2'd0;
  localparam logic [1:0] FUNC_MEMWR  = 2'd1;
  localparam logic [1:0] FUNC_MEMRD  = 2'd2;
  localparam logic [1:0] FUNC_REGSET = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_MEM_BASE = 2'd1;

  // environment call kinds
  localparam logic [1:0] ENV_NONE   = 2'd0;
  localparam logic [1:0] ENV_ECALL  = 2'd1;
  localparam logic [1:0] ENV_EBREAK = 2'd2;

  // major opcodes
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  // funct7 codes
  localparam logic [6:0] F7_BASE  = 7'h00;
  localparam logic [6:0] F7_ALT   = 7'h20;
  localparam logic [6:0] F7_MULDV = 7'h01;
  localparam logic [6:0] F7_CZERO = 7'h07;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        is_signed;
    logic        want_rem;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/rvx_if.sv */
`default_nettype none
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] instruction;
  logic [31:0] instr_addr;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [2:0]  access_bytes;
  logic [4:0]  reg_select;
  modport source (output valid, func, instruction, instr_addr, address, write_data,
                  access_bytes, reg_select, input ready);
  modport sink (input valid, func, instruction, instr_addr, address, write_data,
                access_bytes, reg_select, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] read_data;
  logic [1:0]  env_kind;
  modport source (output valid, ok, next_pc, reg_written, reg_index, reg_value,
                  read_data, env_kind, input ready);
  modport sink (input valid, ok, next_pc, reg_written, reg_index, reg_value,
                read_data, env_kind, output ready);
endinterface

interface rvx_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/rv32im_decode_execute_core_top.sv */
`default_nettype none
// Path: ALU, branch, jump go EXEC then WB, which loads the result beat; register set
//   goes straight to WB; multiply adds MUL; divide waits in DIV (one quotient bit
//   a cycle in the shared divider); memory runs CHK, MEM (one byte a cycle), MEMEND, LDX.
// Throughput: one item at a time; ready again the cycle after the result is registered.
// Reset: synchronous; pc and mem_base go to zero, registers read zero, and the data
//   memory runs a clearing pass over every byte during which no item is taken.
module rv32im_decode_execute_core_top #(
  parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  rvx_in_if.sink    item,
  rvx_out_if.source result,
  rvx_cfg_if.sink   cfg
);
  import rvx_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXEC   = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_CHK    = 9'b000010000,
    S_MEM    = 9'b000100000,
    S_MEMEND = 9'b001000000,
    S_LDX    = 9'b010000000,
    S_WB     = 9'b100000000
  } state_t;

  state_t state;

  // control
  logic [31:0] pc;
  logic [31:0] mem_base;
  logic        out_valid;
  logic        rd_pend;

  // item and working registers
  logic        is_exec;
  logic        is_load;
  logic [31:0] ins;
  logic [31:0] iaddr;
  logic [31:0] ea;
  logic [2:0]  nbytes;
  logic        mem_we;
  logic [31:0] st_data;
  logic [AW-1:0] off;
  logic [1:0]  cnt;
  logic [1:0]  rd_idx;
  logic [31:0] acc;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [1:0]  mul_sel;

  // result under construction
  logic        res_ok;
  logic        res_wr;
  logic [4:0]  res_rd;
  logic [31:0] res_val;
  logic [31:0] res_rdata;
  logic [1:0]  res_env;
  logic [31:0] npc;

  // output register
  logic        o_ok;
  logic [31:0] o_next_pc;
  logic        o_reg_written;
  logic [4:0]  o_reg_index;
  logic [31:0] o_reg_value;
  logic [31:0] o_read_data;
  logic [1:0]  o_env_kind;

  // submodule wires
  logic [31:0] rs1_val;
  logic [31:0] rs2_val;
  logic [4:0]  ra1;
  logic [4:0]  ra2;
  logic        rf_we;
  logic [7:0]  dm_rdata;
  logic        dm_busy;
  logic [AW-1:0] dm_addr;
  logic        dm_we;
  div_req_t    dreq;
  div_rsp_t    drsp;

  // decode fields
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rdi;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] immb;
  logic [31:0] immj;
  logic [31:0] immu;

  // decode results of the execute step
  logic        d_ok;
  logic        d_wr;
  logic [31:0] d_val;
  logic [31:0] d_npc;
  logic [1:0]  d_env;
  logic        d_mem;
  logic        d_we;
  logic [2:0]  d_n;
  logic [31:0] d_ea;
  logic        d_mul;
  logic        d_div;
  logic        taken;

  // range check
  logic [32:0] off_full;
  logic [32:0] end_full;
  logic        n_ok;
  logic        range_ok;
  logic        slot_free;
  logic        wr_eff;
  logic signed [65:0] product;

  assign slot_free = !out_valid || result.ready;
  assign item.ready = (state == S_IDLE) && !dm_busy;
  assign cfg.ready  = 1'b1;

  assign result.valid       = out_valid;
  assign result.ok          = o_ok;
  assign result.next_pc     = o_next_pc;
  assign result.reg_written = o_reg_written;
  assign result.reg_index   = o_reg_index;
  assign result.reg_value   = o_reg_value;
  assign result.read_data   = o_read_data;
  assign result.env_kind    = o_env_kind;

  // issue the register reads on the accept edge so operands are ready in EXEC
  assign ra1 = (state == S_IDLE) ? item.instruction[19:15] : ins[19:15];
  assign ra2 = (state == S_IDLE) ? item.instruction[24:20] : ins[24:20];

  assign wr_eff = res_ok && res_wr && (res_rd != 5'd0);
  assign rf_we  = (state == S_WB) && slot_free && wr_eff;

  rvx_rf u_rf (
    .clk (clk),
    .rst (rst),
    .ra1 (ra1),
    .ra2 (ra2),
    .rd1 (rs1_val),
    .rd2 (rs2_val),
    .we  (rf_we),
    .wa  (res_rd),
    .wd  (res_val)
  );

  assign dm_addr = off + AW'(cnt);
  assign dm_we   = (state == S_MEM) && mem_we;

  rvx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .we    (dm_we),
    .addr  (dm_addr),
    .wdata (st_data[8*cnt +: 8]),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  always_comb begin
    dreq.start     = (state == S_EXEC) && d_div;
    dreq.dividend  = rs1_val;
    dreq.divisor   = rs2_val;
    dreq.is_signed = !f3[0];
    dreq.want_rem  = f3[1];
  end

  rvx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  function automatic logic [31:0] alu(input logic [2:0] fn, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    unique case (fn)
      3'd0:    r = alt ? a - b : a + b;
      3'd1:    r = a << b[4:0];
      3'd2:    r = {31'd0, $signed(a) < $signed(b)};
      3'd3:    r = {31'd0, a < b};
      3'd4:    r = a ^ b;
      3'd5:    r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6:    r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

  assign op   = ins[6:0];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign rdi  = ins[11:7];
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign immu = {ins[31:12], 12'd0};

  // decode and execute one instruction; adders here all run side by side
  always_comb begin
    d_ok  = 1'b1;
    d_wr  = 1'b0;
    d_val = '0;
    d_npc = pc + 32'd4;
    d_env = ENV_NONE;
    d_mem = 1'b0;
    d_we  = 1'b0;
    d_n   = 3'd1 << f3[1:0];
    d_ea  = rs1_val + immi;
    d_mul = 1'b0;
    d_div = 1'b0;
    taken = 1'b0;
    unique case (op)
      OP_REG: begin
        d_wr = 1'b1;
        if (f7 == F7_BASE) begin
          d_val = alu(f3, 1'b0, rs1_val, rs2_val);
        end else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
          d_val = alu(f3, 1'b1, rs1_val, rs2_val);
        end else if (f7 == F7_MULDV) begin
          d_mul = !f3[2];
          d_div = f3[2];
        end else if (f7 == F7_CZERO && f3 == 3'd5) begin
          d_val = (rs2_val != 32'd0) ? rs1_val : 32'd0;
        end else if (f7 == F7_CZERO && f3 == 3'd7) begin
          d_val = (rs2_val != 32'd0) ? 32'd0 : rs1_val;
        end else begin
          d_ok = 1'b0;
        end
      end
      OP_IMM: begin
        d_wr = 1'b1;
        if (f3 == 3'd1) begin
          d_ok = (f7 == F7_BASE);
        end else if (f3 == 3'd5) begin
          d_ok = (f7 == F7_BASE) || (f7 == F7_ALT);
        end
        d_val = alu(f3, (f3 == 3'd5) && (f7 == F7_ALT), rs1_val,
                    (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, ins[24:20]} : immi);
      end
      OP_LOAD: begin
        d_wr  = 1'b1;
        d_mem = 1'b1;
        d_ok  = !(f3 == 3'd3 || f3 > 3'd5);
      end
      OP_STORE: begin
        d_mem = 1'b1;
        d_we  = 1'b1;
        d_ea  = rs1_val + imms;
        d_ok  = (f3 <= 3'd2);
      end
      OP_BRANCH: begin
        unique case (f3)
          3'd0:    taken = (rs1_val == rs2_val);
          3'd1:    taken = (rs1_val != rs2_val);
          3'd4:    taken = $signed(rs1_val) < $signed(rs2_val);
          3'd5:    taken = $signed(rs1_val) >= $signed(rs2_val);
          3'd6:    taken = rs1_val < rs2_val;
          3'd7:    taken = rs1_val >= rs2_val;
          default: d_ok = 1'b0;
        endcase
        if (taken) begin
          d_npc = pc + immb;
        end
      end
      OP_JAL: begin
        d_wr  = 1'b1;
        d_val = iaddr + 32'd4;
        d_npc = pc + immj;
      end
      OP_JALR: begin
        d_ok  = (f3 == 3'd0);
        d_wr  = 1'b1;
        d_val = iaddr + 32'd4;
        d_npc = {d_ea[31:1], 1'b0};
      end
      OP_LUI: begin
        d_wr  = 1'b1;
        d_val = immu;
      end
      OP_AUIPC: begin
        d_wr  = 1'b1;
        d_val = iaddr + immu;
      end
      OP_SYSTEM: begin
        if (f3 == 3'd0 && ins[19:15] == 5'd0 && rdi == 5'd0 && ins[31:21] == 11'd0) begin
          d_env = ins[20] ? ENV_EBREAK : ENV_ECALL;
        end else begin
          d_ok = 1'b0;
        end
      end
      default: d_ok = 1'b0;
    endcase
  end

  // range check: 1 to 4 bytes, base <= ea and offset + bytes <= MEM_BYTES, no wraparound
  assign off_full = {1'b0, ea} - {1'b0, mem_base};
  assign end_full = {1'b0, off_full[31:0]} + {30'd0, nbytes};
  assign n_ok     = (nbytes >= 3'd1) && (nbytes <= 3'd4);
  assign range_ok = n_ok && !off_full[32] && (end_full <= 33'(MEM_BYTES));

  assign product = mul_a * mul_b;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      mem_base  <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      // start_pc only matters at reset, where it is zero; accept and drop it
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_MEM_BASE: mem_base <= cfg.data;
          CFG_START_PC: ;
          default:      ;
        endcase
      end
      // load a fresh result beat, or drop the one taken by the receiver
      if ((state == S_WB) && slot_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= (state == S_MEM) && !mem_we;
      unique case (state)
        S_IDLE: begin
          if (item.valid && !dm_busy) begin
            unique case (item.func)
              FUNC_EXEC:   state <= S_EXEC;
              FUNC_REGSET: state <= S_WB;
              default:     state <= S_CHK;
            endcase
          end
        end
        S_EXEC: begin
          priority if (!d_ok)  state <= S_WB;
          else if (d_mul)      state <= S_MUL;
          else if (d_div)      state <= S_DIV;
          else if (d_mem)      state <= S_CHK;
          else                 state <= S_WB;
        end
        S_MUL: state <= S_WB;
        S_DIV: begin
          if (drsp.done) begin
            state <= S_WB;
          end
        end
        S_CHK: state <= range_ok ? S_MEM : S_WB;
        S_MEM: begin
          if ({1'b0, cnt} == nbytes - 3'd1) begin
            state <= S_MEMEND;
          end
        end
        S_MEMEND: state <= S_LDX;
        S_LDX:    state <= S_WB;
        S_WB: begin
          if (slot_free) begin
            if (res_ok && is_exec) begin
              pc <= npc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      acc[8*rd_idx +: 8] <= dm_rdata;
    end
    unique case (state)
      S_IDLE: begin
        ins       <= item.instruction;
        iaddr     <= item.instr_addr;
        ea        <= item.address;
        nbytes    <= item.access_bytes;
        st_data   <= item.write_data;
        mem_we    <= (item.func == FUNC_MEMWR);
        is_exec   <= (item.func == FUNC_EXEC);
        is_load   <= 1'b0;
        res_ok    <= 1'b1;
        res_wr    <= (item.func == FUNC_REGSET);
        res_rd    <= item.reg_select;
        res_val   <= item.write_data;
        res_rdata <= '0;
        res_env   <= ENV_NONE;
      end
      S_EXEC: begin
        res_ok  <= d_ok;
        res_wr  <= d_wr;
        res_rd  <= rdi;
        res_val <= d_val;
        res_env <= d_env;
        npc     <= d_npc;
        ea      <= d_ea;
        nbytes  <= d_n;
        mem_we  <= d_we;
        is_load <= d_mem && !d_we;
        st_data <= rs2_val;
        mul_a   <= {(f3[1:0] != 2'd3) && rs1_val[31], rs1_val};
        mul_b   <= {(f3[1:0] == 2'd0 || f3[1:0] == 2'd1) && rs2_val[31], rs2_val};
        mul_sel <= f3[1:0];
      end
      S_MUL: begin
        res_val <= (mul_sel == 2'd0) ? product[31:0] : product[63:32];
      end
      S_DIV: begin
        if (drsp.done) begin
          res_val <= drsp.result;
        end
      end
      S_CHK: begin
        off <= off_full[AW-1:0];
        cnt <= '0;
        acc <= '0;
        if (!range_ok) begin
          res_ok <= 1'b0;
        end
      end
      S_MEM: begin
        rd_idx <= cnt;
        cnt    <= cnt + 2'd1;
      end
      S_MEMEND: ;
      S_LDX: begin
        if (!is_exec && !mem_we) begin
          res_rdata <= acc;
        end else if (is_load) begin
          priority case (f3)
            3'd0:    res_val <= {{24{acc[7]}}, acc[7:0]};
            3'd1:    res_val <= {{16{acc[15]}}, acc[15:0]};
            default: res_val <= acc;
          endcase
        end
      end
      S_WB: begin
        if (slot_free) begin
          o_ok          <= res_ok;
          o_next_pc     <= (res_ok && is_exec) ? npc : pc;
          o_reg_written <= wr_eff;
          o_reg_index   <= wr_eff ? res_rd : 5'd0;
          o_reg_value   <= wr_eff ? res_val : 32'd0;
          o_read_data   <= res_ok ? res_rdata : 32'd0;
          o_env_kind    <= res_ok ? res_env : ENV_NONE;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/rvx_rf.sv */
`default_nettype none
module rvx_rf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [4:0]  ra1,
  input  wire logic [4:0]  ra2,
  output logic      [31:0] rd1,
  output logic      [31:0] rd2,
  input  wire logic        we,
  input  wire logic [4:0]  wa,
  input  wire logic [31:0] wd
);
  import rvx_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] valid;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd1 <= valid[ra1] ? mem[ra1] : 32'd0;
    rd2 <= valid[ra2] ? mem[ra2] : 32'd0;
  end

endmodule
`default_nettype wire

/* src/rvx_dmem.sv */
`default_nettype none
module rvx_dmem #(
  parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF,
  localparam int unsigned AW = $clog2(MEM_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata,
  output logic               busy
);
  import rvx_pkg::*;

  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] clr;

  // sweep zeros through every byte after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr  <= '0;
    end else if (busy) begin
      if (clr == AW'(MEM_BYTES - 1)) begin
        busy <= 1'b0;
      end
      clr <= clr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr] <= 8'd0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* src/rvx_div.sv */
`default_nettype none
module rvx_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rvx_pkg::div_req_t  req,
  output rvx_pkg::div_rsp_t       rsp
);
  import rvx_pkg::*;

  logic        busy;
  logic        fin;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic        want_rem;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] pick;
  logic        done_r;
  logic [31:0] result_r;

  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dvs};
  assign pick  = want_rem ? rem : quo;
  assign rsp   = {done_r, result_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fin    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin;
      fin    <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
      end else if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt      <= '0;
      rem      <= '0;
      quo      <= (req.is_signed && req.dividend[31]) ? -req.dividend : req.dividend;
      dvs      <= (req.is_signed && req.divisor[31]) ? -req.divisor : req.divisor;
      want_rem <= req.want_rem;
      // a zero divisor gives an all-ones quotient, never negated
      neg      <= req.is_signed && (req.want_rem ? req.dividend[31] :
                  ((req.dividend[31] ^ req.divisor[31]) && (req.divisor != 32'd0)));
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (fin) begin
      result_r <= neg ? -pick : pick;
    end
  end

endmodule
`default_nettype wire

/* src/rvx_checker.sv */
`default_nettype none
module rvx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_ok,
  input wire logic [31:0] out_next_pc,
  input wire logic        out_reg_written,
  input wire logic [4:0]  out_reg_index,
  input wire logic [31:0] out_reg_value,
  input wire logic [1:0]  out_env_kind
);
  import rvx_pkg::*;

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: drop ready after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting an item");

  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> !out_reg_written && out_env_kind == ENV_NONE)
    else $error("failed item reports a side effect");

  a_x0: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg_written |-> out_reg_index != 5'd0)
    else $error("write to x0 reported");

  a_nowr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg_written |-> out_reg_index == 5'd0 && out_reg_value == 32'd0)
    else $error("register fields not cleared without a write");

endmodule

bind rv32im_decode_execute_core_top rvx_checker u_rvx_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (item.valid),
  .in_ready        (item.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_ok          (result.ok),
  .out_next_pc     (result.next_pc),
  .out_reg_written (result.reg_written),
  .out_reg_index   (result.reg_index),
  .out_reg_value   (result.reg_value),
  .out_env_kind    (result.env_kind)
);
`default_nettype wire

/* tb/rv32im_tb_pkg.sv */
`default_nettype none
package rv32im_tb_pkg;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // multiply / divide funct3
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  // conditional zero funct3
  localparam logic [2:0] F3_CZEQZ = 3'd5;
  localparam logic [2:0] F3_CZNEZ = 3'd7;

  // load / store funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_SH  = 3'd1;
  localparam logic [2:0] F3_SW  = 3'd2;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [2:0] F3_PRIV = 3'd0;

  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

endpackage
`default_nettype wire

/* tb/rv32im_exec_checker.sv */
`default_nettype none
module rv32im_exec_checker
  import rvx_pkg::*;
  import rv32im_tb_pkg::*;
#(
  parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rvx_in_if        item,
  rvx_out_if       result,
  rvx_cfg_if       cfg,
  output int       fail_count,
  output int       pending
);

  typedef struct packed {
    logic        ok;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] rdata;
    logic [1:0]  env;
  } outcome_t;

  outcome_t    outcome_q[$];
  logic [31:0] gpr[32];
  logic [31:0] pc;
  logic [31:0] boot_pc;
  logic [31:0] base;
  logic [7:0]  dmem[MEM_BYTES];

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 32'd1);
    return (v ^ m) - m;
  endfunction

  function automatic bit fits(logic [31:0] addr, logic [31:0] n);
    if (n < 1 || n > 4 || addr < base) return 0;
    return ({32'd0, addr - base} + 64'(n)) <= 64'(MEM_BYTES);
  endfunction

  function automatic logic [31:0] mem_rd(logic [31:0] addr, logic [31:0] n);
    logic [31:0] off, v;
    off = addr - base;
    v = '0;
    for (int i = 0; i < n; i++) v |= 32'(dmem[(off + i) % MEM_BYTES]) << (8 * i);
    return v;
  endfunction

  function automatic void mem_wr(logic [31:0] addr, logic [31:0] n, logic [31:0] v);
    logic [31:0] off;
    off = addr - base;
    for (int i = 0; i < n; i++) dmem[(off + i) % MEM_BYTES] = v[8*i +: 8];
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit rem);
    logic [31:0] ua, ub, r;
    if (b == 0) return rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return rem ? 32'd0 : a;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    if (rem) begin
      r = ua % ub;
      return a[31] ? -r : r;
    end
    r = ua / ub;
    return (a[31] ^ b[31]) ? -r : r;
  endfunction

  function automatic logic [31:0] alu(logic [2:0] f3, bit alt, logic [31:0] a, logic [31:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    case (f3)
      F3_MUL:  return a * b;
      F3_MULH: begin
        p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        return p[63:32];
      end
      F3_MULHSU: begin
        p = {{32{a[31]}}, a} * {32'd0, b};
        return p[63:32];
      end
      F3_MULHU: begin
        p = {32'd0, a} * {32'd0, b};
        return p[63:32];
      end
      F3_DIV:  return sdiv(a, b, 0);
      F3_DIVU: return (b != 0) ? a / b : 32'hFFFF_FFFF;
      F3_REM:  return sdiv(a, b, 1);
      default: return (b != 0) ? a % b : a;
    endcase
  endfunction

  // Apply one accepted beat to the shadow state and return its outcome.
  function automatic outcome_t execute_beat(logic [1:0] func, logic [31:0] ins,
                                            logic [31:0] iaddr, logic [31:0] addr,
                                            logic [31:0] wdata, logic [2:0] nbytes,
                                            logic [4:0] rsel);
    outcome_t    o;
    bit          ok, wr, taken;
    logic [4:0]  rd, r1, r2;
    logic [31:0] val, rdata, npc, a, b, immi, ea, n;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [1:0]  env;
    ok = 1; wr = 0; rd = '0; val = '0; rdata = '0; env = ENV_NONE; npc = pc;
    if (func == FUNC_MEMWR) begin
      ok = fits(addr, 32'(nbytes));
      if (ok) mem_wr(addr, 32'(nbytes), wdata);
    end else if (func == FUNC_MEMRD) begin
      ok = fits(addr, 32'(nbytes));
      if (ok) rdata = mem_rd(addr, 32'(nbytes));
    end else if (func == FUNC_REGSET) begin
      wr = 1; rd = rsel; val = wdata;
    end else begin
      op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25];
      r1 = ins[19:15]; r2 = ins[24:20]; rd = ins[11:7];
      a = gpr[r1]; b = gpr[r2];
      immi = sx({20'd0, ins[31:20]}, 12);
      npc = pc + 32'd4;
      case (op)
        OP_REG: begin
          wr = 1;
          if (f7 == F7_BASE) val = alu(f3, 0, a, b);
          else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) val = alu(f3, 1, a, b);
          else if (f7 == F7_MULDV) val = muldiv(f3, a, b);
          else if (f7 == F7_CZERO && f3 == F3_CZEQZ) val = (b != 0) ? a : 32'd0;
          else if (f7 == F7_CZERO && f3 == F3_CZNEZ) val = (b != 0) ? 32'd0 : a;
          else ok = 0;
        end
        OP_IMM: begin
          wr = 1;
          if (f3 == F3_SLL) ok = (f7 == F7_BASE);
          else if (f3 == F3_SR) ok = (f7 == F7_BASE || f7 == F7_ALT);
          if (ok)
            val = alu(f3, f3 == F3_SR && f7 == F7_ALT, a,
                      (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, r2} : immi);
        end
        OP_LOAD: begin
          wr = 1;
          n = 32'd1 << f3[1:0];
          ea = a + immi;
          if (!(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) || !fits(ea, n)) ok = 0;
          else begin
            val = mem_rd(ea, n);
            if (f3 == F3_LB) val = sx(val, 8);
            else if (f3 == F3_LH) val = sx(val, 16);
          end
        end
        OP_STORE: begin
          ea = a + sx({20'd0, ins[31:25], ins[11:7]}, 12);
          if (f3 > F3_SW || !fits(ea, 32'd1 << f3)) ok = 0;
          else mem_wr(ea, 32'd1 << f3, b);
        end
        OP_BRANCH: begin
          case (f3)
            F3_BEQ:  taken = (a == b);
            F3_BNE:  taken = (a != b);
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = !($signed(a) < $signed(b));
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: begin
              taken = 0;
              ok = 0;
            end
          endcase
          if (taken)
            npc = pc + sx({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        end
        OP_JAL: begin
          wr = 1;
          val = iaddr + 32'd4;
          npc = pc + sx({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        end
        OP_JALR: begin
          if (f3 != F3_JALR) ok = 0;
          else begin
            wr = 1;
            val = iaddr + 32'd4;
            npc = (a + immi) & ~32'd1;
          end
        end
        OP_LUI: begin
          wr = 1;
          val = {ins[31:12], 12'd0};
        end
        OP_AUIPC: begin
          wr = 1;
          val = iaddr + {ins[31:12], 12'd0};
        end
        OP_SYSTEM: begin
          if (f3 == F3_PRIV && r1 == 0 && rd == 0 && ins[31:20] == SYS_ECALL) env = ENV_ECALL;
          else if (f3 == F3_PRIV && r1 == 0 && rd == 0 && ins[31:20] == SYS_EBREAK)
            env = ENV_EBREAK;
          else ok = 0;
        end
        default: ok = 0;
      endcase
      if (ok) pc = npc;
      else wr = 0;
    end
    if (!wr || rd == 0) begin
      wr = 0; rd = '0; val = '0;
    end else begin
      gpr[rd] = val;
    end
    o.ok = ok; o.npc = pc; o.wr = wr; o.rd = rd; o.val = val; o.rdata = rdata;
    o.env = ok ? env : ENV_NONE;
    return o;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      outcome_q.delete();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      boot_pc = '0;
      base = '0;
      pc = boot_pc;
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_START_PC) boot_pc = cfg.data;
        else if (cfg.index == CFG_MEM_BASE) base = cfg.data;
      end
      if (result.valid && result.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got pc %h", $time, result.next_pc);
          fail_count++;
        end else begin
          e = outcome_q.pop_front();
          compare_field("ok", 32'(e.ok), 32'(result.ok));
          compare_field("next_pc", e.npc, result.next_pc);
          compare_field("reg_written", 32'(e.wr), 32'(result.reg_written));
          compare_field("reg_index", 32'(e.rd), 32'(result.reg_index));
          compare_field("reg_value", e.val, result.reg_value);
          compare_field("read_data", e.rdata, result.read_data);
          compare_field("env_kind", 32'(e.env), 32'(result.env_kind));
        end
      end
      if (item.valid && item.ready)
        outcome_q.push_back(execute_beat(item.func, item.instruction, item.instr_addr,
                                         item.address, item.write_data, item.access_bytes,
                                         item.reg_select));
    end
    pending = outcome_q.size();
  end

endmodule
`default_nettype wire

/* tb/rv32im_decode_execute_core_top_tb.sv */
`default_nettype none
module rv32im_decode_execute_core_top_tb;
  import rvx_pkg::*;
  import rv32im_tb_pkg::*;

  localparam int unsigned MEM_BYTES = MEM_BYTES_DEF;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  // idle percentages per side, and the long receiver hold-off request
  int          snd_idle;
  int          rcv_idle;
  bit          hold_req;
  int          hold_cnt;
  logic [31:0] cur_base;

  rvx_in_if  item_ch ();
  rvx_out_if res_ch ();
  rvx_cfg_if cfg_ch ();

  rv32im_decode_execute_core_top #(.MEM_BYTES(MEM_BYTES)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  rv32im_exec_checker #(.MEM_BYTES(MEM_BYTES)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (res_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous cap: reset clearing pass plus every beat at the slowest divide and stalls.
  initial begin
    #16000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: drop ready at random, or hold it low for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Offer one beat, idling first at random; hold it until accepted.
  task automatic send(logic [1:0] func, logic [31:0] ins, logic [31:0] iaddr,
                      logic [31:0] addr, logic [31:0] wdata, logic [2:0] nbytes,
                      logic [4:0] rsel);
    while ($urandom_range(99) < snd_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.func         <= func;
    item_ch.instruction  <= ins;
    item_ch.instr_addr   <= iaddr;
    item_ch.address      <= addr;
    item_ch.write_data   <= wdata;
    item_ch.access_bytes <= nbytes;
    item_ch.reg_select   <= rsel;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic exec(logic [31:0] ins);
    send(FUNC_EXEC, ins, $urandom, $urandom, $urandom, 3'($urandom), 5'($urandom));
  endtask

  task automatic set_reg(logic [4:0] r, logic [31:0] v);
    send(FUNC_REGSET, $urandom, $urandom, $urandom, v, 3'($urandom), r);
  endtask

  task automatic loader(logic [1:0] func, logic [31:0] addr, logic [31:0] wdata,
                        logic [2:0] nbytes);
    send(func, $urandom, $urandom, addr, wdata, nbytes, 5'($urandom));
  endtask

  // Write a register only while idle.
  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Let the checker see the last accepted beat before waiting on its count.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  function automatic logic [31:0] r_ins(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd1;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] sx12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // Aim rs1 + imm near the start or the end of data memory, or just below it.
  task automatic aim_reg(logic [4:0] rs1, logic [11:0] imm);
    logic [31:0] off;
    case ($urandom_range(0, 9))
      0:       off = $urandom_range(MEM_BYTES - 4, MEM_BYTES + 2);
      1:       off = -$urandom_range(1, 4);
      default: off = $urandom_range(0, 255);
    endcase
    set_reg(rs1, cur_base + off - sx12(imm));
  endtask

  task automatic random_beat();
    int          k;
    logic [4:0]  rs1, rs2, rd;
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [31:0] off;
    logic [2:0]  nb;
    k   = $urandom_range(0, 99);
    rs1 = 5'($urandom); rs2 = 5'($urandom); rd = 5'($urandom);
    f3  = 3'($urandom); imm = 12'($urandom);
    nb  = ($urandom_range(0, 11) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    off = ($urandom_range(0, 7) == 0) ? $urandom_range(MEM_BYTES - 4, MEM_BYTES + 8)
                                       : $urandom_range(0, 255);
    if ($urandom_range(0, 15) == 0) off = -$urandom_range(1, 4);
    if (k < 10) set_reg(5'($urandom), edge_word());
    else if (k < 16) loader(FUNC_MEMWR, cur_base + off, $urandom, nb);
    else if (k < 22) loader(FUNC_MEMRD, cur_base + off, $urandom, nb);
    else if (k < 32) begin
      if (rs1 == 0) rs1 = 5'd1;
      aim_reg(rs1, imm);
      if ($urandom_range(0, 1) == 0) begin
        // loads: mostly legal widths, sometimes reserved funct3
        if ($urandom_range(0, 7) != 0) begin
          case ($urandom_range(0, 4))
            0: f3 = F3_LB;
            1: f3 = F3_LH;
            2: f3 = F3_LW;
            3: f3 = F3_LBU;
            default: f3 = F3_LHU;
          endcase
        end
        exec({imm, rs1, f3, rd, OP_LOAD});
      end else begin
        if ($urandom_range(0, 7) != 0) f3 = 3'($urandom_range(F3_SB, F3_SW));
        exec({imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE});
      end
    end else if (k < 42) begin
      case ($urandom_range(0, 2))
        0:       exec(r_ins(F7_BASE, rs2, rs1, f3, rd, OP_REG));
        1:       exec(r_ins(F7_ALT, rs2, rs1, $urandom_range(0, 1) ? F3_ADD : F3_SR, rd, OP_REG));
        default: exec(r_ins(F7_CZERO, rs2, rs1, $urandom_range(0, 1) ? F3_CZEQZ : F3_CZNEZ,
                            rd, OP_REG));
      endcase
    end else if (k < 52) exec(r_ins(F7_MULDV, rs2, rs1, f3, rd, OP_REG));
    else if (k < 64) begin
      if (f3 == F3_SLL) imm[11:5] = F7_BASE;
      else if (f3 == F3_SR) imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
      exec({imm, rs1, f3, rd, OP_IMM});
    end else if (k < 72) exec({7'($urandom), rs2, rs1, f3, 5'($urandom), OP_BRANCH});
    else if (k < 76) exec({20'($urandom), rd, OP_JAL});
    else if (k < 80) exec({imm, rs1, F3_JALR, rd, OP_JALR});
    else if (k < 84) exec({20'($urandom), rd, OP_LUI});
    else if (k < 88) exec({20'($urandom), rd, OP_AUIPC});
    else if (k < 92)
      exec({$urandom_range(0, 1) ? SYS_EBREAK : SYS_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    else exec($urandom);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) random_beat();
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.func = FUNC_EXEC;
    item_ch.instruction = '0;
    item_ch.instr_addr = '0;
    item_ch.address = '0;
    item_ch.write_data = '0;
    item_ch.access_bytes = '0;
    item_ch.reg_select = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_START_PC;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    snd_idle = 0;
    rcv_idle = 0;
    hold_req = 0;
    cur_base = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: divide corners, shift amounts, sltiu, jalr self-link, system words,
    // memory edges, bad sizes, x0 writes.
    set_reg(5'd1, 32'h8000_0000);
    set_reg(5'd2, 32'hFFFF_FFFF);
    set_reg(5'd0, 32'hDEAD_BEEF);
    exec(r_ins(F7_MULDV, 5'd2, 5'd1, F3_DIV, 5'd4, OP_REG));
    exec(r_ins(F7_MULDV, 5'd2, 5'd1, F3_REM, 5'd4, OP_REG));
    exec(r_ins(F7_MULDV, 5'd3, 5'd1, F3_DIV, 5'd5, OP_REG));
    exec(r_ins(F7_MULDV, 5'd3, 5'd1, F3_REMU, 5'd5, OP_REG));
    exec(r_ins(F7_MULDV, 5'd3, 5'd2, F3_DIVU, 5'd5, OP_REG));
    exec(r_ins(F7_MULDV, 5'd2, 5'd1, F3_MULH, 5'd6, OP_REG));
    exec(r_ins(F7_BASE, 5'd2, 5'd1, F3_SLL, 5'd7, OP_REG));
    exec(r_ins(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd7, OP_REG));
    exec({12'hFFF, 5'd1, F3_SLTU, 5'd8, OP_IMM});
    set_reg(5'd9, 32'h0000_1235);
    exec({12'h004, 5'd9, F3_JALR, 5'd9, OP_JALR});
    exec({SYS_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    exec({SYS_EBREAK, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    exec({12'h300, 5'd1, 3'd2, 5'd3, OP_SYSTEM});
    exec(32'h0000_000F);
    loader(FUNC_MEMWR, 32'(MEM_BYTES - 4), 32'h8081_8283, 3'd4);
    loader(FUNC_MEMWR, 32'(MEM_BYTES - 3), 32'h1111_1111, 3'd4);
    loader(FUNC_MEMRD, 32'(MEM_BYTES - 4), '0, 3'd4);
    loader(FUNC_MEMRD, 32'd0, '0, 3'd0);
    loader(FUNC_MEMWR, 32'd0, 32'hFFFF_FFFF, 3'd5);
    set_reg(5'd10, 32'(MEM_BYTES - 4));
    exec({12'd0, 5'd10, F3_LB, 5'd11, OP_LOAD});
    exec({12'd0, 5'd10, F3_LW, 5'd0, OP_LOAD});
    drain();

    // Top of the address space, sender idles less than receiver.
    write_cfg(CFG_START_PC, 32'hFFFF_FFFF);
    cur_base = 32'(0 - MEM_BYTES);
    write_cfg(CFG_MEM_BASE, cur_base);
    snd_idle = 22; rcv_idle = 51;
    random_phase(270);
    drain();

    // Random base, receiver idles less than sender.
    write_cfg(CFG_START_PC, 32'd0);
    cur_base = $urandom;
    write_cfg(CFG_MEM_BASE, cur_base);
    snd_idle = 51; rcv_idle = 22;
    random_phase(270);
    drain();

    // Base zero, no idling; the receiver stalls long enough to back up the input.
    cur_base = '0;
    write_cfg(CFG_MEM_BASE, cur_base);
    snd_idle = 0; rcv_idle = 0;
    hold_req = 1;
    random_phase(260);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
